// ===== hw/rtl/rgb3x3_pkg.sv =====
// Package with payload types and fixed constants of the RGB 3x3 convolution.
package rgb3x3_pkg;

    localparam int PIX_W = 8;
    localparam int POS_W = 10;
    localparam int SIZE_W = 11;
    localparam int MAX_WIDTH = 1024;
    localparam int COEF_W = 8;
    localparam int ROW_LIMIT = 1024;
    localparam int PIX_MAX = 255;
    localparam int SUM_W = 20;

    localparam logic [2:0] CFG_COEF0 = 3'd0;
    localparam logic [2:0] CFG_COEF1 = 3'd1;
    localparam logic [2:0] CFG_COEF2 = 3'd2;
    localparam logic [2:0] CFG_DIV = 3'd3;
    localparam logic [2:0] CFG_WIDTH = 3'd4;
    localparam logic [2:0] CFG_HEIGHT = 3'd5;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic       last_pixel;
    } pix_out_t;

    // One classified window that the back end must filter.
    typedef struct packed {
        logic [8:0][23:0] win;
        logic [9:0]       row;
        logic [9:0]       col;
        logic             last;
    } job_t;

endpackage

// ===== hw/rtl/rgb_3x3_convolution.sv =====
// Top level of the streaming RGB 3x3 convolution filter.
//
//  channel | handshake           | word
//  --------+---------------------+---------------------------------
//  in      | in_valid / in_stall | pix_in_t: RGB sample, frame_start
//  out     | out_valid/out_stall | pix_out_t: RGB result, row, col, last
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The front end takes a pixel per cycle unless in_stall is high; for each
// interior result the back end takes the window, multiply-accumulates nine
// taps (one tap per cycle), divides the sum bit-serially and hands off the
// result when the output is not stalled, taking no new window until then.
// Border pixels give no result. Reset clears counters, window and
// control; the line stores are not cleared, since results only read
// entries written earlier in the same image. A two-word queue sits between
// front and back ends, so a stalled output only stops input when it fills.
module rgb_3x3_convolution (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rgb3x3_pkg::pix_in_t  in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rgb3x3_pkg::pix_out_t out_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [23:0]          cfg_data
);
    logic [23:0] coef0_reg, coef1_reg, coef2_reg;
    logic [7:0]  div_reg;
    logic [10:0] width_reg, height_reg;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef0_reg <= 24'd0;
            coef1_reg <= 24'd256;
            coef2_reg <= 24'd0;
            div_reg <= 8'd1;
            width_reg <= 11'd1024;
            height_reg <= 11'd1024;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rgb3x3_pkg::CFG_COEF0: coef0_reg <= cfg_data;
                rgb3x3_pkg::CFG_COEF1: coef1_reg <= cfg_data;
                rgb3x3_pkg::CFG_COEF2: coef2_reg <= cfg_data;
                rgb3x3_pkg::CFG_DIV: div_reg <= cfg_data[7:0];
                rgb3x3_pkg::CFG_WIDTH: width_reg <= cfg_data[10:0];
                rgb3x3_pkg::CFG_HEIGHT: height_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    logic             fj_valid, fj_stall, bj_valid, bj_stall;
    rgb3x3_pkg::job_t fj_word, bj_word;

    rgb3x3_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .cfg_width(width_reg), .cfg_height(height_reg),
        .job_valid(fj_valid), .job_word(fj_word), .job_stall(fj_stall)
    );

    rgb3x3_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_word(fj_word),
        .rd_valid(bj_valid), .rd_word(bj_word), .rd_stall(bj_stall)
    );

    rgb3x3_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bj_valid), .job_stall(bj_stall), .job_word(bj_word),
        .coef0(coef0_reg), .coef1(coef1_reg), .coef2(coef2_reg),
        .divisor(div_reg),
        .out_valid(out_valid), .out_word(out_word), .out_stall(out_stall)
    );
endmodule

// ===== hw/rtl/rgb3x3_front.sv =====
// Front end: position counters, line stores and the 3x3 window.
module rgb3x3_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rgb3x3_pkg::pix_in_t in_word,
    input  logic [10:0]         cfg_width,
    input  logic [10:0]         cfg_height,
    output logic                job_valid,
    output rgb3x3_pkg::job_t    job_word,
    input  logic                job_stall
);
    // Line store reads are registered, so a pixel goes through a stage
    // holding the read data before the window shifts.
    logic [23:0] mem1 [rgb3x3_pkg::MAX_WIDTH];
    logic [23:0] mem2 [rgb3x3_pkg::MAX_WIDTH];
    logic [23:0] a1_reg, a2_reg;

    logic [9:0] col_reg, col_next, row_reg, row_next;
    logic       s1_valid_reg;
    logic [23:0] s1_pix_reg;
    logic [9:0] s1_row_reg, s1_col_reg;
    logic       s1_last_reg;
    logic [8:0][23:0] win_reg;
    logic       job_valid_reg;
    logic [9:0] job_row_reg, job_col_reg;
    logic       job_last_reg;

    logic [11:0] w_eff, h_eff;
    logic [9:0]  c, r;
    logic        accept, adv;

    always_comb
    begin
        w_eff = (cfg_width > 11'(rgb3x3_pkg::MAX_WIDTH)) ?
                12'(rgb3x3_pkg::MAX_WIDTH) : {1'b0, cfg_width};
        h_eff = (cfg_height > 11'(rgb3x3_pkg::ROW_LIMIT)) ?
                12'(rgb3x3_pkg::ROW_LIMIT) : {1'b0, cfg_height};
        if (w_eff == 12'd0) w_eff = 12'd1;
        if (h_eff == 12'd0) h_eff = 12'd1;
        c = in_word.frame_start ? 10'd0 : col_reg;
        r = in_word.frame_start ? 10'd0 : row_reg;
        if ({2'b0, c} >= w_eff) c = 10'd0;
        if ({2'b0, r} >= h_eff) r = 10'd0;
        if ({2'b0, c} + 12'd1 >= w_eff)
        begin
            col_next = 10'd0;
            row_next = ({2'b0, r} + 12'd1 >= h_eff) ? 10'd0 : r + 10'd1;
        end
        else
        begin
            col_next = c + 10'd1;
            row_next = r;
        end
    end

    // Stage 2 advances when the output slot is free or being drained.
    assign adv = !job_valid_reg || !job_stall;
    assign in_stall = s1_valid_reg && !adv;
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a1_reg <= mem1[c];
            a2_reg <= mem2[c];
            mem1[c] <= {in_word.blue_in, in_word.green_in, in_word.red_in};
            mem2[c] <= mem1[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
            job_valid_reg <= 1'b0;
            win_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (adv)
            begin
                s1_valid_reg <= accept;
                job_valid_reg <= 1'b0;
                if (s1_valid_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        win_reg[i*3] <= win_reg[i*3+1];
                        win_reg[i*3+1] <= win_reg[i*3+2];
                    end
                    win_reg[2] <= a2_reg;
                    win_reg[5] <= a1_reg;
                    win_reg[8] <= s1_pix_reg;
                    job_valid_reg <= (s1_row_reg >= 10'd2) && (s1_col_reg >= 10'd2);
                end
            end
            else if (accept)
            begin
                // The first stage was empty, so it holds the word until the
                // output slot frees up.
                s1_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= {in_word.blue_in, in_word.green_in, in_word.red_in};
            s1_row_reg <= r;
            s1_col_reg <= c;
            s1_last_reg <= ({2'b0, r} + 12'd1 == h_eff) && ({2'b0, c} + 12'd1 == w_eff);
        end
        if (adv && s1_valid_reg)
        begin
            job_row_reg <= s1_row_reg - 10'd1;
            job_col_reg <= s1_col_reg - 10'd1;
            job_last_reg <= s1_last_reg;
        end
    end

    assign job_valid = job_valid_reg;
    assign job_word.win = win_reg;
    assign job_word.row = job_row_reg;
    assign job_word.col = job_col_reg;
    assign job_word.last = job_last_reg;
endmodule

// ===== hw/rtl/rgb3x3_queue.sv =====
// Two-entry queue between the front end and the filter back end.
module rgb3x3_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_stall,
    input  rgb3x3_pkg::job_t wr_word,
    output logic             rd_valid,
    output rgb3x3_pkg::job_t rd_word,
    input  logic             rd_stall
);
    rgb3x3_pkg::job_t ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_word = ent_reg[rp_reg];
    assign push = wr_valid && !wr_stall;
    assign pop = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (push) ent_reg[wp_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== hw/rtl/rgb3x3_back.sv =====
// Back end: weighted sum, divide by the divisor and clamp for one window.
module rgb3x3_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_stall,
    input  rgb3x3_pkg::job_t job_word,
    input  logic [23:0]      coef0,
    input  logic [23:0]      coef1,
    input  logic [23:0]      coef2,
    input  logic [7:0]       divisor,
    output logic             out_valid,
    output rgb3x3_pkg::pix_out_t out_word,
    input  logic             out_stall
);
    localparam int SW = rgb3x3_pkg::SUM_W;
    localparam int CW = rgb3x3_pkg::COEF_W;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC = 3'd1;
    localparam logic [2:0] ST_DIV = 3'd2;
    localparam logic [2:0] ST_OUT = 3'd3;

    logic [2:0] st_reg;
    logic [3:0] k_reg;
    logic [4:0] bit_reg;
    rgb3x3_pkg::job_t job_reg;
    logic signed [SW-1:0] acc_reg [3];
    logic [SW-1:0] quo_reg [3];
    logic [SW-1:0] rem_reg [3];
    logic [SW-1:0] mag [3];
    logic [23:0] crow;
    logic signed [CW-1:0] cf;
    logic [7:0] dv;
    logic [SW-1:0] trial [3];
    logic [7:0] res [3];

    // Tap k weighs kernel row k/3 and column k%3; columns sit CW bits apart.
    always_comb
    begin
        case (k_reg)
            4'd0, 4'd1, 4'd2: crow = coef0;
            4'd3, 4'd4, 4'd5: crow = coef1;
            default:          crow = coef2;
        endcase
        case (k_reg)
            4'd0, 4'd3, 4'd6: cf = crow[0 +: CW];
            4'd1, 4'd4, 4'd7: cf = crow[CW +: CW];
            default:          cf = crow[2*CW +: CW];
        endcase
        dv = (divisor == 8'd0) ? 8'd1 : divisor;
        for (int ch = 0; ch < 3; ch++)
        begin
            mag[ch] = acc_reg[ch][SW-1] ? SW'(-acc_reg[ch]) : SW'(acc_reg[ch]);
            trial[ch] = {rem_reg[ch][SW-2:0], mag[ch][bit_reg]};
            if (acc_reg[ch][SW-1] || quo_reg[ch] == '0)
                res[ch] = 8'd0;
            else if (quo_reg[ch] > SW'(rgb3x3_pkg::PIX_MAX))
                res[ch] = 8'(rgb3x3_pkg::PIX_MAX);
            else
                res[ch] = quo_reg[ch][7:0];
        end
    end

    assign job_stall = (st_reg != ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);
    assign out_word.red_out = res[0];
    assign out_word.green_out = res[1];
    assign out_word.blue_out = res[2];
    assign out_word.out_row = job_reg.row;
    assign out_word.out_col = job_reg.col;
    assign out_word.last_pixel = job_reg.last;

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && job_valid) job_reg <= job_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            k_reg <= '0;
            bit_reg <= '0;
            for (int ch = 0; ch < 3; ch++)
            begin
                acc_reg[ch] <= '0;
                quo_reg[ch] <= '0;
                rem_reg[ch] <= '0;
            end
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        st_reg <= ST_MAC;
                        k_reg <= '0;
                        for (int ch = 0; ch < 3; ch++) acc_reg[ch] <= '0;
                    end
                end
                ST_MAC:
                begin
                    // One tap per cycle, three colors in parallel.
                    for (int ch = 0; ch < 3; ch++)
                        acc_reg[ch] <= acc_reg[ch] + SW'(signed'({1'b0,
                            job_reg.win[k_reg][ch*8 +: 8]})) * SW'(cf);
                    if (k_reg == 4'd8)
                    begin
                        st_reg <= ST_DIV;
                        bit_reg <= 5'(SW - 1);
                        for (int ch = 0; ch < 3; ch++)
                        begin
                            quo_reg[ch] <= '0;
                            rem_reg[ch] <= '0;
                        end
                    end
                    k_reg <= k_reg + 4'd1;
                end
                ST_DIV:
                begin
                    // Restoring division of the magnitude, one bit a cycle.
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        if (trial[ch] >= SW'(dv))
                        begin
                            rem_reg[ch] <= trial[ch] - SW'(dv);
                            quo_reg[ch] <= {quo_reg[ch][SW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[ch] <= trial[ch];
                            quo_reg[ch] <= {quo_reg[ch][SW-2:0], 1'b0};
                        end
                    end
                    if (bit_reg == 5'd0) st_reg <= ST_OUT;
                    bit_reg <= bit_reg - 5'd1;
                end
                ST_OUT:
                begin
                    if (!out_stall) st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/rgb3x3_checker.sv =====
// Port-level checker for the convolution filter, bound to the top level.
module rgb3x3_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input rgb3x3_pkg::pix_out_t out_word,
    input logic                 cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.out_row != 10'd0 && out_word.out_col != 10'd0)
        else $error("result reported on a border position");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("results closer than the back end allows");
endmodule

bind rgb_3x3_convolution rgb3x3_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word), .cfg_ready(cfg_ready)
);
